// File: hw/rtl/fwrm_pkg.sv
// Shared types and codes for the FIFO with running maximum.
// Used by fwrm_cmp, fwrm_mem and fifo_with_running_max_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fwrm_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // operation codes
  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_MAX = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP,
    ST_APPEND,
    ST_DEQ,
    ST_MAX,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/fwrm_cmp.sv
// Shared signed comparator used by the sequencer for candidate pops and dequeue matching.
// Depends on fwrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fwrm_cmp #(
  parameter int DATA_WIDTH = fwrm_pkg::DATA_WIDTH_DEF
) (
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output fwrm_pkg::cmp_res_t         res
);

  always_comb begin
    res.lt = $signed(a) < $signed(b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

// File: hw/rtl/fwrm_mem.sv
// Single-port-write, single-port-read memory with registered read data.
// Holds either the value ring or the candidate ring; depends on fwrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fwrm_mem #(
  parameter  int DEPTH      = fwrm_pkg::DEPTH_DEF,
  parameter  int DATA_WIDTH = fwrm_pkg::DATA_WIDTH_DEF,
  localparam int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fifo_with_running_max_core.sv
// FIFO of signed values that also reports its largest held value.
// Channels: input (in_valid/in_stall, in_func, in_value_in) carries one operation per
// transaction: enqueue, dequeue or read maximum. Output (out_valid/out_stall) returns
// exactly one result per transaction: out_value_out, out_status, out_occupancy.
// One operation at a time; in_stall is high from acceptance until the result is taken.
// Path from acceptance: dispatch, then the dequeue or max state, then result; errors and
// unused codes go from dispatch to result; enqueue goes from dispatch through p pop
// passes and an append to result. p is the number of shared comparator passes over the
// deque tail: 0 when the deque is empty, k when all k candidates are dropped, otherwise
// k + 1 (the last pass finds a candidate that stays). A dropped candidate never returns,
// so k averages at most one per enqueue. After the result is taken the block returns to
// idle and can accept the next operation.
// The result register holds while out_stall is high; no new transaction is taken
// until the result has been accepted.
// Reset (rst_n low, synchronous) empties both the value ring and the candidate deque;
// memory contents are not cleared and need no clearing pass.
// Enqueue on a full FIFO is dropped with status full; dequeue or max on an empty
// FIFO returns zero with status empty.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_running_max_core #(
  parameter  int DEPTH      = fwrm_pkg::DEPTH_DEF,
  parameter  int DATA_WIDTH = fwrm_pkg::DATA_WIDTH_DEF,
  localparam int AW         = $clog2(DEPTH),
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_func,
  input  wire logic [DATA_WIDTH-1:0] in_value_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [DATA_WIDTH-1:0] out_value_out,
  output logic      [1:0]            out_status,
  output logic      [CW-1:0]         out_occupancy
);

  fwrm_pkg::state_t state_r, state_nxt;

  logic [1:0]            func_r, func_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [AW-1:0]         v_head_r, v_head_nxt;
  logic [CW-1:0]         v_cnt_r, v_cnt_nxt;
  logic [AW-1:0]         c_head_r, c_head_nxt;
  logic [CW-1:0]         c_cnt_r, c_cnt_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic                  v_we, v_re, c_we, c_re;
  logic [AW-1:0]         v_waddr, v_raddr, c_waddr, c_raddr;
  logic [DATA_WIDTH-1:0] v_rd, c_rd, cmp_b;
  fwrm_pkg::cmp_res_t    cmp_res;

  // ring index: (base + off) mod DEPTH, base + off always below 2*DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  fwrm_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_value_mem (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (x_r),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rd)
  );

  fwrm_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_cand_mem (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (x_r),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  // candidate is compared with the new value on pops, with the head value on dequeue
  assign cmp_b = (state_r == fwrm_pkg::ST_DEQ) ? v_rd : x_r;

  fwrm_cmp #(.DATA_WIDTH(DATA_WIDTH)) u_cmp (
    .a   (c_rd),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fwrm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fwrm_pkg::ST_DISPATCH;
        end
      end
      fwrm_pkg::ST_DISPATCH: begin
        case (func_r)
          fwrm_pkg::FUNC_ENQ: begin
            if (v_cnt_r == CW'(DEPTH)) begin
              state_nxt = fwrm_pkg::ST_RESULT;
            end else if (c_cnt_r == '0) begin
              state_nxt = fwrm_pkg::ST_APPEND;
            end else begin
              state_nxt = fwrm_pkg::ST_POP;
            end
          end
          fwrm_pkg::FUNC_DEQ: begin
            state_nxt = (v_cnt_r == '0) ? fwrm_pkg::ST_RESULT : fwrm_pkg::ST_DEQ;
          end
          fwrm_pkg::FUNC_MAX: begin
            state_nxt = (v_cnt_r == '0 || c_cnt_r == '0) ? fwrm_pkg::ST_RESULT
                                                        : fwrm_pkg::ST_MAX;
          end
          default: state_nxt = fwrm_pkg::ST_RESULT;
        endcase
      end
      fwrm_pkg::ST_POP: begin
        if (!cmp_res.lt || c_cnt_r == CW'(1)) begin
          state_nxt = fwrm_pkg::ST_APPEND;
        end
      end
      fwrm_pkg::ST_APPEND,
      fwrm_pkg::ST_DEQ,
      fwrm_pkg::ST_MAX: state_nxt = fwrm_pkg::ST_RESULT;
      fwrm_pkg::ST_RESULT: begin
        if (!out_stall) begin
          state_nxt = fwrm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fwrm_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    func_nxt       = func_r;
    x_nxt          = x_r;
    v_head_nxt     = v_head_r;
    v_cnt_nxt      = v_cnt_r;
    c_head_nxt     = c_head_r;
    c_cnt_nxt      = c_cnt_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    v_we           = 1'b0;
    v_waddr        = wrap_add(v_head_r, v_cnt_r);
    v_re           = 1'b0;
    v_raddr        = v_head_r;
    c_we           = 1'b0;
    c_waddr        = wrap_add(c_head_r, c_cnt_r);
    c_re           = 1'b0;
    c_raddr        = c_head_r;
    case (state_r)
      fwrm_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          x_nxt    = in_value_in;
        end
      end
      fwrm_pkg::ST_DISPATCH: begin
        out_value_nxt  = '0;
        out_status_nxt = fwrm_pkg::STAT_OK;
        case (func_r)
          fwrm_pkg::FUNC_ENQ: begin
            if (v_cnt_r == CW'(DEPTH)) begin
              out_status_nxt = fwrm_pkg::STAT_FULL;
            end else begin
              v_we      = 1'b1;
              v_cnt_nxt = v_cnt_r + CW'(1);
              if (c_cnt_r != '0) begin
                c_re    = 1'b1;
                c_raddr = wrap_add(c_head_r, c_cnt_r - CW'(1));
              end
            end
          end
          fwrm_pkg::FUNC_DEQ: begin
            if (v_cnt_r == '0) begin
              out_status_nxt = fwrm_pkg::STAT_EMPTY;
            end else begin
              v_re = 1'b1;
              c_re = 1'b1;
            end
          end
          fwrm_pkg::FUNC_MAX: begin
            if (v_cnt_r == '0 || c_cnt_r == '0) begin
              out_status_nxt = fwrm_pkg::STAT_EMPTY;
            end else begin
              c_re = 1'b1;
            end
          end
          default: ;
        endcase
      end
      fwrm_pkg::ST_POP: begin
        // drop tail candidates strictly below the new value, keep equal ones
        if (cmp_res.lt) begin
          c_cnt_nxt = c_cnt_r - CW'(1);
          if (c_cnt_r != CW'(1)) begin
            c_re    = 1'b1;
            c_raddr = wrap_add(c_head_r, c_cnt_r - CW'(2));
          end
        end
      end
      fwrm_pkg::ST_APPEND: begin
        c_we      = 1'b1;
        c_cnt_nxt = c_cnt_r + CW'(1);
      end
      fwrm_pkg::ST_DEQ: begin
        out_value_nxt = v_rd;
        if (c_cnt_r != '0 && cmp_res.eq) begin
          c_head_nxt = wrap_add(c_head_r, CW'(1));
          c_cnt_nxt  = c_cnt_r - CW'(1);
        end
        v_head_nxt = wrap_add(v_head_r, CW'(1));
        v_cnt_nxt  = v_cnt_r - CW'(1);
      end
      fwrm_pkg::ST_MAX: begin
        out_value_nxt = c_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fwrm_pkg::ST_IDLE;
      v_head_r <= '0;
      v_cnt_r  <= '0;
      c_head_r <= '0;
      c_cnt_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      v_head_r <= v_head_nxt;
      v_cnt_r  <= v_cnt_nxt;
      c_head_r <= c_head_nxt;
      c_cnt_r  <= c_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    x_r          <= x_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall      = (state_r != fwrm_pkg::ST_IDLE);
  assign out_valid     = (state_r == fwrm_pkg::ST_RESULT);
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = v_cnt_r;

endmodule

`default_nettype wire
